/* design/b64d_pkg.sv */
// Package for the base64 stream decoder: result types, class codes and the
// character classification function. No dependencies.
package b64d_pkg;

  localparam int unsigned MAX_CHARS_DEF = 65536;
  localparam int unsigned MAX_RESULTS = 4;

  // Classification codes for one input character; 0 to 63 are sextet values.
  localparam logic [7:0] CODE_PLUS  = 8'd62;
  localparam logic [7:0] CODE_SLASH = 8'd63;
  localparam logic [7:0] CODE_SPACE = 8'd64;
  localparam logic [7:0] CODE_PAD   = 8'd65;
  localparam logic [7:0] CODE_BAD   = 8'd255;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_END_OK  = 2'd1,
    KIND_END_ERR = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0]  data;
    kind_e       kind;
    logic [15:0] count;
  } result_t;

  // All results that one item causes, in delivery order starting at res[0].
  typedef struct packed {
    logic [2:0]          num;
    result_t [MAX_RESULTS-1:0] res;
  } bundle_t;

  function automatic logic [7:0] b64d_classify(input logic [7:0] c);
    logic [7:0] r;
    r = CODE_BAD;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      r = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = c - 8'h30 + 8'd52;
    end else if (c == 8'h2b) begin
      r = CODE_PLUS;
    end else if (c == 8'h2f) begin
      r = CODE_SLASH;
    end else if (c == 8'h3d) begin
      r = CODE_PAD;
    end else if (c == 8'h09 || c == 8'h0a || c == 8'h0b || c == 8'h0d || c == 8'h20) begin
      r = CODE_SPACE;
    end
    return r;
  endfunction

endpackage

/* design/b64d_decode.sv */
// Decoder state and the single-pass logic that turns one character into its
// bundle of results. Depends on b64d_pkg.
module b64d_decode import b64d_pkg::*; #(
  parameter int unsigned MAX_CHARS = MAX_CHARS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        move_i,
  input  logic [7:0]  char_code_i,
  input  logic        has_char_i,
  input  logic        is_last_i,
  input  logic [15:0] out_capacity_i,
  output bundle_t     bundle_o
);

  localparam int unsigned CT_W = $clog2(MAX_CHARS + 1);
  localparam int unsigned NW   = CT_W + 2;
  localparam int unsigned CW   = (NW > 16) ? NW : 16;

  logic [17:0]     acc_q, acc_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            pad_q, pad_d;
  logic            err_q, err_d;
  logic [CT_W-1:0] ct_q, ct_d;
  logic [15:0]     bo_q, bo_d;

  logic [CT_W-1:0] ct_inc;
  logic [7:0]      code;
  logic            active;
  logic            is_sext;
  logic [23:0]     word;
  logic [7:0]      byt [3];
  logic [1:0]      nbytes;
  logic [NW-1:0]   need;
  logic            end_err;
  logic [15:0]     cntk [4];
  logic [16:0]     sum;
  logic [15:0]     end_count;

  always_comb begin
    ct_inc = ct_q;
    if (has_char_i && ct_q < CT_W'(MAX_CHARS)) begin
      ct_inc = ct_q + CT_W'(1);
    end
    code    = b64d_classify(char_code_i);
    active  = has_char_i && !pad_q && !err_q;
    err_d   = err_q | (active && code == CODE_BAD);
    pad_d   = pad_q | (active && code == CODE_PAD);
    is_sext = active && code < CODE_SPACE;

    acc_d  = acc_q;
    cnt_d  = cnt_q;
    nbytes = 2'd0;
    word   = {acc_q, code[5:0]};
    for (int i = 0; i < 3; i++) begin
      byt[i] = 8'd0;
    end
    if (is_sext) begin
      if (cnt_q == 2'd3) begin
        byt[0] = word[23:16];
        byt[1] = word[15:8];
        byt[2] = word[7:0];
        nbytes = 2'd3;
        acc_d  = '0;
        cnt_d  = 2'd0;
      end else begin
        acc_d = {acc_q[11:0], code[5:0]};
        cnt_d = cnt_q + 2'd1;
      end
    end

    // Bytes allowed for the characters seen: floor(total * 3 / 4).
    need    = (NW'(ct_inc) + NW'({ct_inc, 1'b0})) >> 2;
    end_err = err_d || (CW'(out_capacity_i) < CW'(need)) || cnt_d == 2'd1;

    // Leftover flush only follows an item that completed no group.
    if (is_last_i && !end_err) begin
      if (cnt_d == 2'd2) begin
        byt[0] = acc_d[11:4];
        nbytes = 2'd1;
      end else if (cnt_d == 2'd3) begin
        byt[0] = acc_d[17:10];
        byt[1] = acc_d[9:2];
        nbytes = 2'd2;
      end
    end

    cntk[0] = bo_q;
    for (int k = 1; k < 4; k++) begin
      sum     = {1'b0, bo_q} + 17'(k);
      cntk[k] = sum[16] ? 16'hffff : sum[15:0];
    end
    end_count = cntk[nbytes];

    bundle_o.num = {1'b0, nbytes} + {2'b00, is_last_i};
    for (int i = 0; i < MAX_RESULTS; i++) begin
      bundle_o.res[i].data  = 8'd0;
      bundle_o.res[i].kind  = end_err ? KIND_END_ERR : KIND_END_OK;
      bundle_o.res[i].count = end_count;
      if (i < 3 && 2'(i) < nbytes) begin
        bundle_o.res[i].data  = byt[i];
        bundle_o.res[i].kind  = KIND_DATA;
        bundle_o.res[i].count = cntk[i+1];
      end
    end

    ct_d = ct_inc;
    bo_d = end_count;
    if (is_last_i) begin
      acc_d = '0;
      cnt_d = 2'd0;
      pad_d = 1'b0;
      err_d = 1'b0;
      ct_d  = '0;
      bo_d  = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= 2'd0;
      pad_q <= 1'b0;
      err_q <= 1'b0;
      ct_q  <= '0;
      bo_q  <= 16'd0;
    end else if (move_i) begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
      pad_q <= pad_d;
      err_q <= err_d;
      ct_q  <= ct_d;
      bo_q  <= bo_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_clear_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (move_i && is_last_i) |=> (cnt_q == 2'd0 && ct_q == '0 && bo_q == 16'd0 && !pad_q && !err_q))
    else $error("decoder state not cleared after end of message");
  a_count_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ct_q <= CT_W'(MAX_CHARS)))
    else $error("character total passed its saturation limit");
`endif

endmodule

/* design/b64d_out_queue.sv */
// Result register: holds the bundle of one item and hands its results out one
// word per cycle while the output is not stalled. Depends on b64d_pkg.
module b64d_out_queue import b64d_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t bundle_i,
  output logic    ready_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t head_o,
  output logic    last_of_run_o
);

  result_t    ent_q [MAX_RESULTS];
  logic [2:0] num_q;
  logic       pop;

  assign pop           = (num_q != 3'd0) && !out_stall_i;
  assign ready_o       = (num_q == 3'd0) || (num_q == 3'd1 && pop);
  assign out_valid_o   = num_q != 3'd0;
  assign head_o        = ent_q[0];
  assign last_of_run_o = num_q == 3'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= 3'd0;
    end else if (push_i) begin
      num_q <= bundle_i.num;
    end else if (pop) begin
      num_q <= num_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        ent_q[i] <= bundle_i.res[i];
      end
    end else if (pop) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        ent_q[i] <= ent_q[i+1];
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_push_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (num_q == 3'd0 || (num_q == 3'd1 && pop)))
    else $error("bundle pushed over pending results");
  a_num_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    num_q <= 3'(MAX_RESULTS))
    else $error("result count out of range");
`endif

endmodule

/* design/base64_stream_decoder_core.sv */
// Top level of the base64 stream decoder: input register, configuration
// port, decoder and result register. Depends on b64d_pkg, b64d_decode and
// b64d_out_queue.
//
//   channel  direction  handshake                    payload
//   in       input      in_valid_i / in_stall_o      char_code_i, has_char_i, is_last_i
//   out      output     out_valid_o / out_stall_i    data_byte_o, kind_o, byte_count_o,
//                                                    last_of_run_o
//   cfg      input      psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// A word is held in the input register, then is decoded in one pass into the result
// register, which delivers one result per cycle while the output is not stalled.
// An item with k results (k from 0 to 4) holds the result register until all k are
// delivered, so the rate is one item per cycle when each item gives at most one result and the output is not stalled.
// Reset is asynchronous and active low; it clears the decoder state and sets
// out_capacity to 65535.
// A stalled output backs up into the input register, which then stalls the input.
module base64_stream_decoder_core import b64d_pkg::*; #(
  parameter int unsigned MAX_CHARS = MAX_CHARS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  input  logic        has_char_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  data_byte_o,
  output logic [1:0]  kind_o,
  output logic [15:0] byte_count_o,
  output logic        last_of_run_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        a_valid_q;
  logic [7:0]  a_char_q;
  logic        a_has_q;
  logic        a_last_q;
  logic [15:0] cap_q;

  logic        accept;
  logic        move;
  logic        q_ready;
  bundle_t     bundle;
  result_t     head;

  assign accept     = in_valid_i && !in_stall_o;
  assign move       = a_valid_q && q_ready;
  assign in_stall_o = a_valid_q && !q_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (accept) begin
      a_valid_q <= 1'b1;
    end else if (move) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_char_q <= char_code_i;
      a_has_q  <= has_char_i;
      a_last_q <= is_last_i;
    end
  end

  // One register exists, at addresses 0 to 3 (paddr[2] low); writes to addresses 4 to 7 are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 16'hffff;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      cap_q <= pwdata[15:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {16'd0, cap_q};

  b64d_decode #(
    .MAX_CHARS(MAX_CHARS)
  ) u_decode (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .move_i         (move),
    .char_code_i    (a_char_q),
    .has_char_i     (a_has_q),
    .is_last_i      (a_last_q),
    .out_capacity_i (cap_q),
    .bundle_o       (bundle)
  );

  b64d_out_queue u_out_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (move),
    .bundle_i      (bundle),
    .ready_o       (q_ready),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .head_o        (head),
    .last_of_run_o (last_of_run_o)
  );

  assign data_byte_o  = head.data;
  assign kind_o       = head.kind;
  assign byte_count_o = head.count;

`ifndef NO_ASSERTIONS
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != KIND_DATA) |-> last_of_run_o)
    else $error("end result is not the final result of its item");
  a_end_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != KIND_DATA) |-> (data_byte_o == 8'd0))
    else $error("end result carries a data byte");
`endif

endmodule
